FILE: hdl/vlrq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlrq_pkg
// shared word types, operation codes and status codes of the record queue
// ----------------------------------------------------------------------------
package vlrq_pkg;

    // input kinds
    localparam logic [2:0] K_CLEAR      = 3'd0;
    localparam logic [2:0] K_PUSH_BEGIN = 3'd1;
    localparam logic [2:0] K_PUSH_DATA  = 3'd2;
    localparam logic [2:0] K_FRONT_READ = 3'd3;
    localparam logic [2:0] K_POP        = 3'd4;
    // classified op for kinds that mean nothing
    localparam logic [2:0] K_BAD        = 3'd5;

    // result status
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_SPACE = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_BAD_SEQ  = 3'd3;
    localparam logic [2:0] ST_RANGE    = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [10:0] length;
        logic [7:0]  data_byte;
        logic [9:0]  byte_offset;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [10:0] front_size;
        logic [7:0]  read_byte;
    } t_out_word;

    // classified command handed from front to back
    typedef struct packed {
        logic [2:0]  op;
        logic [10:0] length;
        logic [7:0]  data_byte;
        logic [9:0]  byte_offset;
    } t_cmd;

endpackage

FILE: hdl/vlrq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlrq_front
// accepts input words, classifies the kind, holds them in a two-entry queue
// ----------------------------------------------------------------------------
module vlrq_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  vlrq_pkg::t_in_word i_in_word,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output vlrq_pkg::t_cmd    o_cmd
);
    vlrq_pkg::t_cmd r_q [2];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_cnt;
    logic [1:0]     n_cnt;
    logic           w_push;
    logic           w_pop;
    vlrq_pkg::t_cmd w_cls;

    always_comb begin
        w_cls.op          = (i_in_word.kind > vlrq_pkg::K_POP) ? vlrq_pkg::K_BAD
                                                               : i_in_word.kind;
        w_cls.length      = i_in_word.length;
        w_cls.data_byte   = i_in_word.data_byte;
        w_cls.byte_offset = i_in_word.byte_offset;
    end

    assign o_in_ready  = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];
    assign w_push      = i_in_valid && o_in_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) n_cnt = r_cnt + 2'd1;
        else if (!w_push && w_pop) n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wr] <= w_cls;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (w_pop) r_rd <= ~r_rd;
            r_cnt <= n_cnt;
        end
    end
endmodule

FILE: hdl/vlrq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlrq_back
// sequencer over the byte store: placement, header write, header read, results
// ----------------------------------------------------------------------------
module vlrq_back #(
    parameter int CAPACITY     = 1024,
    parameter int HEADER_BYTES = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    output logic                o_cmd_ready,
    input  vlrq_pkg::t_cmd      i_cmd,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output vlrq_pkg::t_out_word o_out_word
);
    localparam int AW = $clog2(CAPACITY);
    localparam int SW = $clog2(CAPACITY + 2048 + 8) + 1;
    localparam int HR = (HEADER_BYTES >= 2) ? 2 : 1;
    localparam logic [SW-1:0] CAP_W = SW'(CAPACITY);
    localparam logic [SW-1:0] HB_W  = SW'(HEADER_BYTES);
    localparam logic [1:0] HB_LAST = 2'(HEADER_BYTES - 1);
    localparam logic [1:0] HR_LAST = 2'(HR - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HW   = 3'd1;
    localparam logic [2:0] S_HRQ  = 3'd2;
    localparam logic [2:0] S_HCP  = 3'd3;
    localparam logic [2:0] S_LOC  = 3'd4;
    localparam logic [2:0] S_BRD  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [7:0] r_mem [CAPACITY];
    logic [7:0] r_rdata;

    logic [2:0]  r_state, n_state;
    logic [1:0]  r_cnt, n_cnt;
    logic [SW-1:0] r_head, n_head, r_tail, n_tail, r_wp, n_wp, r_pend, n_pend;
    logic [SW-1:0] r_base, n_base;
    logic [10:0] r_left, n_left, r_len, n_len;
    logic        r_open, n_open;
    vlrq_pkg::t_cmd      r_cmd, n_cmd;
    vlrq_pkg::t_out_word r_res, n_res, r_out, n_out;
    logic        r_ov, n_ov;

    logic          w_slot_free;
    logic          w_take;
    logic          w_we;
    logic [SW-1:0] w_waddr, w_raddr;
    logic [7:0]    w_wdata;
    logic [SW-1:0] w_len_in, w_len_r, w_ds, w_pay, w_next;
    logic          w_too_long;

    assign w_slot_free = !r_ov || i_out_ready;
    assign o_cmd_ready = (r_state == S_IDLE) && w_slot_free;
    assign w_take      = i_cmd_valid && o_cmd_ready;
    assign o_out_valid = r_ov;
    assign o_out_word  = r_out;

    assign w_len_in   = {{(SW-11){1'b0}}, i_cmd.length};
    assign w_len_r    = {{(SW-11){1'b0}}, r_len};
    assign w_ds       = HB_W + w_len_in;
    assign w_too_long = (HEADER_BYTES == 1) && (i_cmd.length[10:8] != 3'd0);

    // head record placement from the header length
    always_comb begin
        if (r_head + HB_W <= CAP_W) begin
            if (r_head + HB_W + w_len_r <= CAP_W) begin
                w_pay  = r_head + HB_W;
                w_next = r_head + HB_W + w_len_r;
            end else begin
                w_pay  = '0;
                w_next = w_len_r;
            end
        end else begin
            w_pay  = HB_W;
            w_next = w_len_r + HB_W;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_head  = r_head;
        n_tail  = r_tail;
        n_wp    = r_wp;
        n_pend  = r_pend;
        n_base  = r_base;
        n_left  = r_left;
        n_len   = r_len;
        n_open  = r_open;
        n_cmd   = r_cmd;
        n_res   = r_res;
        n_out   = r_out;
        n_ov    = r_ov && !i_out_ready;
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = '0;
        w_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    n_cmd = i_cmd;
                    n_out = '0;
                    n_ov  = 1'b1;
                    unique case (i_cmd.op)
                        vlrq_pkg::K_CLEAR: begin
                            n_head = '0;
                            n_tail = '0;
                            n_wp   = '0;
                            n_left = '0;
                            n_pend = '0;
                            n_open = 1'b0;
                        end
                        vlrq_pkg::K_PUSH_BEGIN: begin
                            if (r_open) begin
                                n_out.status = vlrq_pkg::ST_BAD_SEQ;
                            end else if (w_too_long) begin
                                n_out.status = vlrq_pkg::ST_NO_SPACE;
                            end else begin
                                n_out.status = vlrq_pkg::ST_OK;
                                n_ov   = 1'b0;
                                n_len  = i_cmd.length;
                                n_left = i_cmd.length;
                                n_open = 1'b1;
                                n_cnt  = '0;
                                n_state = S_HW;
                                if (r_tail >= r_head) begin
                                    if (r_tail + w_ds <= CAP_W) begin
                                        n_base = r_tail;
                                        n_wp   = r_tail + HB_W;
                                        n_pend = r_tail + w_ds;
                                    end else if (r_tail + HB_W <= CAP_W
                                                 && w_len_in < r_head) begin
                                        n_base = r_tail;
                                        n_wp   = '0;
                                        n_pend = w_len_in;
                                    end else if (w_ds < r_head) begin
                                        n_base = '0;
                                        n_wp   = HB_W;
                                        n_pend = w_ds;
                                    end else begin
                                        n_out.status = vlrq_pkg::ST_NO_SPACE;
                                    end
                                end else if (!(r_tail + w_ds < r_head)) begin
                                    n_out.status = vlrq_pkg::ST_NO_SPACE;
                                end else begin
                                    n_base = r_tail;
                                    n_wp   = r_tail + HB_W;
                                    n_pend = r_tail + w_ds;
                                end
                                if (n_out.status != vlrq_pkg::ST_OK) begin
                                    // no room: undo the staged push
                                    n_ov    = 1'b1;
                                    n_state = S_IDLE;
                                    n_len   = r_len;
                                    n_left  = r_left;
                                    n_open  = r_open;
                                    n_base  = r_base;
                                    n_wp    = r_wp;
                                    n_pend  = r_pend;
                                end
                            end
                        end
                        vlrq_pkg::K_PUSH_DATA: begin
                            if (!r_open) begin
                                n_out.status = vlrq_pkg::ST_BAD_SEQ;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = r_wp;
                                w_wdata = i_cmd.data_byte;
                                n_wp    = r_wp + SW'(1);
                                n_left  = r_left - 11'd1;
                                if (r_left == 11'd1) begin
                                    n_tail = r_pend;
                                    n_open = 1'b0;
                                end
                            end
                        end
                        vlrq_pkg::K_FRONT_READ, vlrq_pkg::K_POP: begin
                            if (r_head == r_tail) begin
                                n_out.status = vlrq_pkg::ST_EMPTY;
                            end else begin
                                n_ov    = 1'b0;
                                n_base  = (r_head + HB_W <= CAP_W) ? r_head : '0;
                                n_cnt   = '0;
                                n_len   = '0;
                                n_state = S_HRQ;
                            end
                        end
                        default: begin
                            n_out.status = vlrq_pkg::ST_BAD_SEQ;
                        end
                    endcase
                end
            end
            S_HW: begin
                w_we    = 1'b1;
                w_waddr = r_base + {{(SW-2){1'b0}}, r_cnt};
                case (r_cnt)
                    2'd0:    w_wdata = r_len[7:0];
                    2'd1:    w_wdata = {5'd0, r_len[10:8]};
                    default: w_wdata = 8'd0;
                endcase
                if (r_cnt == HB_LAST) begin
                    if (r_len == 11'd0) begin
                        n_tail = r_pend;
                        n_open = 1'b0;
                        n_left = '0;
                    end
                    n_res   = '0;
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 2'd1;
                end
            end
            S_HRQ: begin
                w_raddr = r_base + {{(SW-2){1'b0}}, r_cnt};
                n_state = S_HCP;
            end
            S_HCP: begin
                if (r_cnt == 2'd0) n_len[7:0] = r_rdata;
                else n_len[10:8] = r_rdata[2:0];
                if (r_cnt == HR_LAST) begin
                    n_state = S_LOC;
                end else begin
                    n_cnt   = r_cnt + 2'd1;
                    n_state = S_HRQ;
                end
            end
            S_LOC: begin
                n_res = '0;
                n_res.front_size = r_len;
                if (r_cmd.op == vlrq_pkg::K_POP) begin
                    n_head  = w_next;
                    n_state = S_DONE;
                end else if ({1'b0, r_cmd.byte_offset} >= r_len) begin
                    n_res.status = vlrq_pkg::ST_RANGE;
                    n_state = S_DONE;
                end else begin
                    w_raddr = w_pay + {{(SW-10){1'b0}}, r_cmd.byte_offset};
                    n_state = S_BRD;
                end
            end
            S_BRD: begin
                n_res.read_byte = r_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_slot_free) begin
                    n_out   = r_res;
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we && (w_waddr < CAP_W)) r_mem[w_waddr[AW-1:0]] <= w_wdata;
        if (w_raddr < CAP_W) r_rdata <= r_mem[w_raddr[AW-1:0]];
        else r_rdata <= 8'd0;
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_base <= n_base;
        r_len  <= n_len;
        r_cmd  <= n_cmd;
        r_res  <= n_res;
        r_out  <= n_out;
        r_wp   <= n_wp;
        r_pend <= n_pend;
        r_left <= n_left;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_open  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_open  <= n_open;
            r_ov    <= n_ov;
        end
    end
endmodule

FILE: hdl/variable_length_record_ring_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_length_record_ring_queue_top
// byte ring store of length-prefixed records with push, read and pop words
// ----------------------------------------------------------------------------
// Each input word gives exactly one result word. Clear, push_data, rejected
// and empty words are answered straight from the idle state; push_begin writes
// the header one byte a cycle through the single store write port; pop and
// front_read read the header a byte at a time through the single registered
// read port of the byte store, and front_read then reads the addressed byte.
// A two-word queue in front takes words while the back end works or a result
// waits. The store has no reset; the pointers reset to an empty queue.
module variable_length_record_ring_queue_top #(
    parameter int CAPACITY     = 1024,
    parameter int HEADER_BYTES = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  vlrq_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output vlrq_pkg::t_out_word o_out_word
);
    // classified commands between the two halves
    logic           w_cmd_valid;
    logic           w_cmd_ready;
    vlrq_pkg::t_cmd w_cmd;

    vlrq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    // back end owns the store and the ring pointers
    vlrq_back #(
        .CAPACITY     (CAPACITY),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );
endmodule

FILE: hdl/vlrq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlrq_checker
// port-level checks on result words of the record queue
// ----------------------------------------------------------------------------
module vlrq_props (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input vlrq_pkg::t_out_word o_out_word
);
    // stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // empty, no space and bad sequence carry no size
    a_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status == vlrq_pkg::ST_EMPTY
                        || o_out_word.status == vlrq_pkg::ST_NO_SPACE
                        || o_out_word.status == vlrq_pkg::ST_BAD_SEQ)
        |-> o_out_word.front_size == 11'd0)
        else $error("size on a failed word");

    // only a good read gives a byte
    a_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status != vlrq_pkg::ST_OK
        |-> o_out_word.read_byte == 8'd0)
        else $error("byte on a failed word");

    // status stays within the defined codes
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.status <= vlrq_pkg::ST_RANGE)
        else $error("undefined status");
endmodule

bind variable_length_record_ring_queue_top vlrq_props u_vlrq_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
